@@ rtl/core/markup_context_probability_calibrator_core_macros.svh @@
// Assertion helpers shared by the calibrator RTL.
`ifndef MARKUP_CONTEXT_PROBABILITY_CALIBRATOR_CORE_MACROS_SVH
`define MARKUP_CONTEXT_PROBABILITY_CALIBRATOR_CORE_MACROS_SVH

// Implication checked every clock outside reset.
`define MCPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked every clock outside reset.
`define MCPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mcpc_pkg.sv @@
`timescale 1ns / 1ps
package mcpc_pkg;

  localparam int BIT_SLOTS_DEF   = 8;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int BINS            = 16;
  localparam int MARKUP_STATES   = 5;
  localparam int PROB_W          = 16;

  localparam logic [1:0] CFG_SHRINK = 2'd0;
  localparam logic [1:0] CFG_STR1   = 2'd1;
  localparam logic [1:0] CFG_STR2   = 2'd2;
  localparam logic [1:0] CFG_DIV    = 2'd3;

  typedef enum logic [2:0] {
    MK_TEXT  = 3'd0,
    MK_LT    = 3'd1,
    MK_TAG   = 3'd2,
    MK_DQ    = 3'd3,
    MK_SQ    = 3'd4
  } markup_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_LATCH,
    ST_DIV,
    ST_FIX,
    ST_EMIT,
    ST_WRITE
  } state_t;

  function automatic markup_t next_markup(markup_t st, logic [7:0] b);
    markup_t n;
    n = MK_TEXT;
    case (st)
      MK_TEXT: n = (b == 8'h3C) ? MK_LT : MK_TEXT;
      MK_LT, MK_TAG: begin
        if (b == 8'h3E)      n = MK_TEXT;
        else if (b == 8'h22) n = MK_DQ;
        else if (b == 8'h27) n = MK_SQ;
        else                 n = MK_TAG;
      end
      MK_DQ: n = (b == 8'h22) ? MK_TAG : MK_DQ;
      MK_SQ: n = (b == 8'h27) ? MK_TAG : MK_SQ;
      default: n = MK_TEXT;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/core/mcpc_ram.sv @@
`timescale 1ns / 1ps
module mcpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/mcpc_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module mcpc_div #(
  parameter int NW = 64,
  parameter int DW = 52
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);
  import mcpc_pkg::*;
  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   r_r, r_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [DW:0]   trial;

  always_comb begin
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    q_nxt   = q_r;
    r_nxt   = r_r;
    d_nxt   = d_r;
    trial   = {r_r[DW-1:0], q_r[NW-1]};
    if (go) begin
      q_nxt   = num;
      r_nxt   = '0;
      d_nxt   = den;
      cnt_nxt = CW'(NW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      // Shift in one numerator bit, subtract when it fits
      if (trial >= {1'b0, d_r}) begin
        r_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        r_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = run_r && (cnt_r == CW'(1));
  assign quo  = q_r;
  assign rem  = r_r[DW-1:0];
endmodule

@@ rtl/core/markup_context_probability_calibrator_core.sv @@
`timescale 1ns / 1ps
// Channel  | Ports                              | Handshake
// input    | in_* fields, start, busy           | start && !busy
// result   | out_* fields, out_valid            | one-cycle strobe
// config   | cfg_index, cfg_data, cfg_valid/rdy | cfg_valid && cfg_ready
// A byte item is taken while idle and leaves busy low. A bit item holds busy
// through read, operand latch, four corrections on one bit-per-cycle divider
// (NUMW steps plus a clamp step each; NUMW = SUM_WIDTH+4 = 53 at defaults), result
// strobe and write-back. After reset a clearing pass over all 5*BIT_SLOTS*16 table
// entries (640 at defaults) zeroes the tables with busy high. The receiver cannot
// stall; each result strobes once.
module markup_context_probability_calibrator_core #(
  parameter int BIT_SLOTS   = mcpc_pkg::BIT_SLOTS_DEF,
  parameter int COUNT_WIDTH = mcpc_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [7:0]  in_byte_value,
  input  logic [2:0]  in_bit_position,
  input  logic        in_coded_bit,
  input  logic [15:0] in_base_probability,
  output logic        out_valid,
  output logic [15:0] out_context_prob_first,
  output logic [15:0] out_context_prob_second,
  output logic [15:0] out_plain_prob_first,
  output logic [15:0] out_plain_prob_second,
  output logic [2:0]  out_markup_state,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import mcpc_pkg::*;
`include "markup_context_probability_calibrator_core_macros.svh"

  // Signed residual total: residuals of up to 2^16 in magnitude over up to 2^COUNT_WIDTH-1 events
  localparam int SUM_WIDTH = COUNT_WIDTH + 17;
  localparam int AD  = MARKUP_STATES * BIT_SLOTS * BINS;
  localparam int BD  = BIT_SLOTS * BINS;
  localparam int AAW = $clog2(AD);
  localparam int BAW = $clog2(BD);
  localparam int PW  = (BIT_SLOTS > 1) ? $clog2(BIT_SLOTS) : 1;
  localparam int EW  = SUM_WIDTH + COUNT_WIDTH;
  localparam int DENW = COUNT_WIDTH + 1 + 4;  // d*(count+k)
  localparam int NUMW = SUM_WIDTH + 4;        // |sum|*s
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  // Configuration registers
  logic [15:0] shrink_r;
  logic [3:0]  str1_r, str2_r, sdiv_r;
  markup_t     mk_r;
  state_t      st_r, st_nxt;
  logic [AAW-1:0] clr_r;
  logic [1:0]  ph_r;

  // Latched item
  logic [15:0] base_r;
  logic        bit_r;
  logic [AAW-1:0] ai_r;
  logic [BAW-1:0] bi_r;
  logic [SUM_WIDTH-1:0]   a_sum_r, b_sum_r;
  logic [COUNT_WIDTH-1:0] a_cnt_r, b_cnt_r;
  logic [15:0] res_r [4];

  logic [EW-1:0] a_rd, b_rd;
  logic          we;
  logic [AAW-1:0] a_waddr;
  logic [BAW-1:0] b_waddr;
  logic [EW-1:0] a_wd, b_wd;

  assign cfg_ready = (st_r == ST_IDLE);
  assign busy      = (st_r != ST_IDLE);

  // Index of the item
  logic [PW-1:0] pos_c;
  always_comb begin
    if (32'(in_bit_position) >= BIT_SLOTS) pos_c = PW'(BIT_SLOTS - 1);
    else pos_c = PW'(in_bit_position);
  end
  logic [AAW-1:0] ai_c;
  logic [BAW-1:0] bi_c;
  assign ai_c = AAW'((32'(mk_r) * BIT_SLOTS + 32'(pos_c)) * BINS
                + 32'(in_base_probability[15:12]));
  assign bi_c = BAW'(32'(pos_c) * BINS + 32'(in_base_probability[15:12]));

  mcpc_ram #(.WIDTH(EW), .DEPTH(AD)) u_aware (
    .clk, .we, .waddr(a_waddr), .wdata(a_wd),
    .raddr((st_r == ST_IDLE) ? ai_c : ai_r), .rdata(a_rd));
  mcpc_ram #(.WIDTH(EW), .DEPTH(BD)) u_blind (
    .clk, .we, .waddr(b_waddr), .wdata(b_wd),
    .raddr((st_r == ST_IDLE) ? bi_c : bi_r), .rdata(b_rd));

  // Operands of the division that starts this cycle; the clamp keeps the
  // sign of the correction that finishes
  logic [1:0]  ph_op;
  logic [SUM_WIDTH-1:0]   sel_sum;
  logic [COUNT_WIDTH-1:0] sel_cnt;
  logic [3:0]  sel_s, kdiv;
  logic [15:0] keff;
  logic        op_neg, neg;
  logic [SUM_WIDTH-1:0] mag;
  logic [NUMW-1:0] num;
  logic [DENW-1:0] den;
  always_comb begin
    ph_op   = (st_r == ST_FIX) ? ph_r + 2'd1 : ph_r;
    sel_sum = ph_op[1] ? b_sum_r : a_sum_r;
    sel_cnt = ph_op[1] ? b_cnt_r : a_cnt_r;
    sel_s   = ph_op[0] ? str2_r : str1_r;
    keff    = (shrink_r == '0) ? 16'd1 : shrink_r;
    kdiv    = (sdiv_r == '0) ? 4'd1 : sdiv_r;
    op_neg  = sel_sum[SUM_WIDTH-1];
    neg     = ph_r[1] ? b_sum_r[SUM_WIDTH-1] : a_sum_r[SUM_WIDTH-1];
    mag     = op_neg ? (~sel_sum + 1'b1) : sel_sum;
    // trunc(|sum|*s / (d*den)) equals the model's exact split form
    num     = NUMW'(mag) * NUMW'(sel_s);
    den     = DENW'((COUNT_WIDTH+1)'(sel_cnt) + (COUNT_WIDTH+1)'(keff)) * DENW'(kdiv);
  end

  logic          dgo, ddone;
  logic [NUMW-1:0] quo;
  logic [DENW-1:0] drem;
  mcpc_div #(.NW(NUMW), .DW(DENW)) u_div (
    .clk, .rst_n, .go(dgo), .num, .den, .done(ddone), .quo, .rem(drem));
  assign dgo = (st_r == ST_LATCH) || (st_r == ST_FIX && ph_r != 2'd3);

  // Clamp base +/- quotient
  logic signed [NUMW+1:0] sres;
  logic [15:0] clamped;
  always_comb begin
    sres = neg ? ((NUMW+2)'(base_r) - (NUMW+2)'(quo))
               : ((NUMW+2)'(base_r) + (NUMW+2)'(quo));
    if (sres < 1)            clamped = 16'd1;
    else if (sres > 65535)   clamped = 16'hFFFF;
    else                     clamped = sres[15:0];
  end

  // Residual update
  logic signed [SUM_WIDTH-1:0] resid;
  assign resid = (bit_r ? SUM_WIDTH'(65536) : '0) - SUM_WIDTH'(base_r);
  always_comb begin
    we      = (st_r == ST_CLEAR) || (st_r == ST_WRITE);
    a_waddr = (st_r == ST_CLEAR) ? clr_r : ai_r;
    b_waddr = (st_r == ST_CLEAR) ? BAW'(clr_r) : bi_r;
    a_wd    = '0;
    b_wd    = '0;
    if (st_r == ST_WRITE) begin
      a_wd = (a_cnt_r == CMAX) ? {a_sum_r, a_cnt_r}
                               : {a_sum_r + resid, a_cnt_r + 1'b1};
      b_wd = (b_cnt_r == CMAX) ? {b_sum_r, b_cnt_r}
                               : {b_sum_r + resid, b_cnt_r + 1'b1};
    end
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: if (clr_r == AAW'(AD - 1)) st_nxt = ST_IDLE;
      ST_IDLE:  if (start && in_mode) st_nxt = ST_READ;
      ST_READ:  st_nxt = ST_LATCH;
      ST_LATCH: st_nxt = ST_DIV;
      ST_DIV:   if (ddone) st_nxt = ST_FIX;
      ST_FIX:   st_nxt = (ph_r == 2'd3) ? ST_EMIT : ST_DIV;
      ST_EMIT:  st_nxt = ST_WRITE;
      ST_WRITE: st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    out_valid               = (st_r == ST_EMIT);
    out_context_prob_first  = res_r[0];
    out_context_prob_second = res_r[1];
    out_plain_prob_first    = res_r[2];
    out_plain_prob_second   = res_r[3];
    out_markup_state        = 3'(mk_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_CLEAR;
      clr_r    <= '0;
      ph_r     <= '0;
      mk_r     <= MK_TEXT;
      shrink_r <= 16'd256;
      str1_r   <= 4'd1;
      str2_r   <= 4'd2;
      sdiv_r   <= 4'd2;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SHRINK: shrink_r <= cfg_data;
          CFG_STR1:   str1_r   <= cfg_data[3:0];
          CFG_STR2:   str2_r   <= cfg_data[3:0];
          CFG_DIV:    sdiv_r   <= cfg_data[3:0];
          default:    ;
        endcase
      end
      // Advance the tracker on byte transfers
      if (st_r == ST_IDLE && start && !in_mode) mk_r <= next_markup(mk_r, in_byte_value);
      if (st_r == ST_LATCH) ph_r <= '0;
      if (st_r == ST_FIX) ph_r <= ph_r + 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && start && in_mode) begin
      base_r <= in_base_probability;
      bit_r  <= in_coded_bit;
      ai_r   <= ai_c;
      bi_r   <= bi_c;
    end
    if (st_r == ST_READ) begin
      {a_sum_r, a_cnt_r} <= a_rd;
      {b_sum_r, b_cnt_r} <= b_rd;
    end
    if (st_r == ST_FIX) res_r[ph_r] <= clamped;
  end

  `MCPC_ASSERT_IMP(a_emit_idle, clk, rst_n, out_valid, !cfg_ready,
    "result strobe while idle")
  `MCPC_ASSERT_NXT(a_emit_write, clk, rst_n, out_valid, st_r == ST_WRITE,
    "write-back does not follow result")
  `MCPC_ASSERT_IMP(a_res_range, clk, rst_n, out_valid,
    out_context_prob_first != 16'd0 && out_plain_prob_second != 16'd0,
    "zero probability emitted")
  `MCPC_ASSERT_IMP(a_mk_range, clk, rst_n, 1'b1, 3'(mk_r) <= 3'd4,
    "markup tracker out of range")
endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import mcpc_pkg::*;

  typedef struct {
    bit          mode;
    logic [7:0]  byte_val;
    logic [2:0]  pos;
    bit          coded;
    logic [15:0] base;
  } item_t;

  typedef struct {
    logic [15:0] ctx1;
    logic [15:0] ctx2;
    logic [15:0] pln1;
    logic [15:0] pln2;
    logic [2:0]  mk;
  } probs_t;

  typedef struct {
    item_t  it;
    bit     typed;
    probs_t want;
  } row_t;

  localparam int AW_DEPTH = MARKUP_STATES * BIT_SLOTS_DEF * BINS;
  localparam int BL_DEPTH = BIT_SLOTS_DEF * BINS;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH_DEF) - 1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_mode = 1'b0;
  logic [7:0]  in_byte_value = '0;
  logic [2:0]  in_bit_position = '0;
  logic        in_coded_bit = 1'b0;
  logic [15:0] in_base_probability = '0;
  logic        out_valid;
  logic [15:0] out_context_prob_first;
  logic [15:0] out_context_prob_second;
  logic [15:0] out_plain_prob_first;
  logic [15:0] out_plain_prob_second;
  logic [2:0]  out_markup_state;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_SHRINK;
  logic [15:0] cfg_data = '0;

  // predictor state and register copies
  markup_t         tracker;
  longint          aw_sum [AW_DEPTH];
  longint unsigned aw_cnt [AW_DEPTH];
  longint          bl_sum [BL_DEPTH];
  longint unsigned bl_cnt [BL_DEPTH];
  longint unsigned shrink_r, str1_r, str2_r, div_r;

  probs_t pending_probs[$];
  int     errors = 0;
  int     results_seen = 0;
  int     bytes_sent = 0;
  int     bits_sent = 0;
  bit     allow_idle = 1'b1;

  markup_context_probability_calibrator_core u_top (.*);

  always #6 clk = ~clk;

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic markup_t tracker_next(markup_t st, logic [7:0] b);
    case (st)
      MK_TEXT: return (b == "<") ? MK_LT : MK_TEXT;
      MK_LT, MK_TAG: begin
        if (b == ">") return MK_TEXT;
        if (b == "\"") return MK_DQ;
        if (b == "'") return MK_SQ;
        return MK_TAG;
      end
      MK_DQ: return (b == "\"") ? MK_TAG : MK_DQ;
      MK_SQ: return (b == "'") ? MK_TAG : MK_SQ;
      default: return MK_TEXT;
    endcase
  endfunction

  // base + trunc(sum*s / (d*(count+k))), clamped to 1..65535
  function automatic logic [15:0] calibrated(logic [15:0] base, longint sum,
                                             longint unsigned cnt, longint unsigned s);
    longint unsigned k, d, den, mag, q, r, qs, a, bq, adj;
    longint res;
    bit neg;
    k = (shrink_r != 0) ? shrink_r : 1;
    d = (div_r != 0) ? div_r : 1;
    den = cnt + k;
    neg = sum < 0;
    mag = neg ? -sum : sum;
    q = mag / den;
    r = mag % den;
    qs = q * s;
    a = qs / d;
    bq = qs % d;
    adj = a + (bq * den + r * s) / (d * den);
    res = longint'(base) + (neg ? -longint'(adj) : longint'(adj));
    if (res < 1) res = 1;
    if (res > 65535) res = 65535;
    return res[15:0];
  endfunction

  // advance the predictor on an accepted transfer; returns 1 if a result follows
  function automatic bit calibrate_item(item_t it, output probs_t p);
    int ai, bi, pos;
    longint resid;
    p = '{default: '0};
    if (!it.mode) begin
      tracker = tracker_next(tracker, it.byte_val);
      return 1'b0;
    end
    pos = (it.pos >= BIT_SLOTS_DEF) ? BIT_SLOTS_DEF - 1 : it.pos;
    ai = (int'(tracker) * BIT_SLOTS_DEF + pos) * BINS + it.base[15:12];
    bi = pos * BINS + it.base[15:12];
    p.ctx1 = calibrated(it.base, aw_sum[ai], aw_cnt[ai], str1_r);
    p.ctx2 = calibrated(it.base, aw_sum[ai], aw_cnt[ai], str2_r);
    p.pln1 = calibrated(it.base, bl_sum[bi], bl_cnt[bi], str1_r);
    p.pln2 = calibrated(it.base, bl_sum[bi], bl_cnt[bi], str2_r);
    p.mk = tracker;
    resid = (it.coded ? 65536 : 0) - longint'(it.base);
    // saturated entries freeze
    if (aw_cnt[ai] < COUNT_MAX) begin
      aw_sum[ai] += resid;
      aw_cnt[ai]++;
    end
    if (bl_cnt[bi] < COUNT_MAX) begin
      bl_sum[bi] += resid;
      bl_cnt[bi]++;
    end
    return 1'b1;
  endfunction

  // check each result strobe against the oldest expectation
  always @(posedge clk) begin
    probs_t w;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_probs.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        errors++;
      end else begin
        w = pending_probs.pop_front();
        if (out_context_prob_first !== w.ctx1)
          report_mismatch("context_prob_first", out_context_prob_first, w.ctx1);
        if (out_context_prob_second !== w.ctx2)
          report_mismatch("context_prob_second", out_context_prob_second, w.ctx2);
        if (out_plain_prob_first !== w.pln1)
          report_mismatch("plain_prob_first", out_plain_prob_first, w.pln1);
        if (out_plain_prob_second !== w.pln2)
          report_mismatch("plain_prob_second", out_plain_prob_second, w.pln2);
        if (out_markup_state !== w.mk)
          report_mismatch("markup_state", 16'(out_markup_state), 16'(w.mk));
      end
    end
  end

  // drive one item and hold it until the transfer
  task automatic send_item(item_t it, bit typed, probs_t want);
    probs_t p;
    int gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    in_mode = it.mode;
    in_byte_value = it.byte_val;
    in_bit_position = it.pos;
    in_coded_bit = it.coded;
    in_base_probability = it.base;
    do @(posedge clk); while (busy);
    if (calibrate_item(it, p)) begin
      pending_probs.push_back(typed ? want : p);
      bits_sent++;
    end else begin
      bytes_sent++;
    end
  endtask

  // wait until the block is idle with nothing outstanding
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_probs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SHRINK: shrink_r = val;
      CFG_STR1:   str1_r = val & 16'hF;
      CFG_STR2:   str2_r = val & 16'hF;
      default:    div_r = val & 16'hF;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic item_t random_item();
    item_t it;
    int sel;
    it.mode = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 9);
    // often markup punctuation so the tracker walks all states
    case (sel)
      0: it.byte_val = "<";
      1: it.byte_val = ">";
      2: it.byte_val = "\"";
      3: it.byte_val = "'";
      default: it.byte_val = 8'($urandom_range(0, 255));
    endcase
    it.pos = 3'($urandom_range(0, 7));
    it.coded = 1'($urandom_range(0, 1));
    // bias toward two bins so entries build up history
    if ($urandom_range(0, 2) != 0)
      it.base = {($urandom_range(0, 1) ? 4'hF : 4'h3), 12'($urandom)};
    else
      it.base = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  initial begin
    row_t   steer[$];
    probs_t none;
    item_t  it;
    int     phase;
    none = '{default: '0};
    for (int i = 0; i < AW_DEPTH; i++) begin
      aw_sum[i] = 0;
      aw_cnt[i] = 0;
    end
    for (int i = 0; i < BL_DEPTH; i++) begin
      bl_sum[i] = 0;
      bl_cnt[i] = 0;
    end
    tracker = MK_TEXT;
    shrink_r = 256;
    str1_r = 1;
    str2_r = 2;
    div_r = 2;

    // fresh tables give the clamped base back
    steer.push_back('{'{1, 8'h00, 3'd0, 1, 16'h0000}, 1, '{16'd1, 16'd1, 16'd1, 16'd1, MK_TEXT}});
    steer.push_back('{'{1, 8'hFF, 3'd7, 0, 16'hFFFF}, 1,
                      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, MK_TEXT}});
    steer.push_back('{'{1, 8'h00, 3'd3, 1, 16'h8000}, 1,
                      '{16'h8000, 16'h8000, 16'h8000, 16'h8000, MK_TEXT}});
    // repeat hits on used entries
    steer.push_back('{'{1, 8'h00, 3'd0, 1, 16'h0001}, 0, none});
    steer.push_back('{'{1, 8'h00, 3'd7, 1, 16'hFFFE}, 0, none});
    // walk the markup tracker through every state
    steer.push_back('{'{0, "<", 3'd0, 0, 16'h0}, 0, none});
    steer.push_back('{'{1, 8'h00, 3'd2, 1, 16'h1234}, 0, none});
    steer.push_back('{'{0, "a", 3'd0, 0, 16'h0}, 0, none});
    steer.push_back('{'{1, 8'h00, 3'd2, 0, 16'h1234}, 0, none});
    steer.push_back('{'{0, "\"", 3'd0, 0, 16'h0}, 0, none});
    steer.push_back('{'{1, 8'h00, 3'd5, 1, 16'hC000}, 0, none});
    steer.push_back('{'{0, ">", 3'd0, 0, 16'h0}, 0, none});
    steer.push_back('{'{0, "\"", 3'd0, 0, 16'h0}, 0, none});
    steer.push_back('{'{0, "'", 3'd0, 0, 16'h0}, 0, none});
    steer.push_back('{'{1, 8'h00, 3'd5, 0, 16'hC000}, 0, none});
    steer.push_back('{'{0, "'", 3'd0, 0, 16'h0}, 0, none});
    steer.push_back('{'{0, ">", 3'd0, 0, 16'h0}, 0, none});
    steer.push_back('{'{1, 8'h00, 3'd0, 0, 16'h0000}, 0, none});
    steer.push_back('{'{0, "<", 3'd0, 0, 16'h0}, 0, none});
    steer.push_back('{'{0, ">", 3'd0, 0, 16'h0}, 0, none});
    steer.push_back('{'{1, 8'h00, 3'd1, 1, 16'h7FFF}, 0, none});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (steer[i]) send_item(steer[i].it, steer[i].typed, steer[i].want);
    drain();

    for (phase = 0; phase < 5; phase++) begin
      // register settings per phase, extremes included; upper bits must be ignored
      case (phase)
        0: begin
          write_reg(CFG_SHRINK, 16'd1);
          write_reg(CFG_STR1, 16'hFFFF);
          write_reg(CFG_STR2, 16'h00FF);
          write_reg(CFG_DIV, 16'h0001);
        end
        1: begin
          write_reg(CFG_SHRINK, 16'd0);
          write_reg(CFG_STR1, 16'h0000);
          write_reg(CFG_STR2, 16'hFFF0);
          write_reg(CFG_DIV, 16'h0000);
        end
        2: begin
          write_reg(CFG_SHRINK, 16'hFFFF);
          write_reg(CFG_STR1, 16'd7);
          write_reg(CFG_STR2, 16'd15);
          write_reg(CFG_DIV, 16'h000F);
        end
        default: begin
          write_reg(CFG_SHRINK, 16'($urandom));
          write_reg(CFG_STR1, 16'($urandom));
          write_reg(CFG_STR2, 16'($urandom));
          write_reg(CFG_DIV, 16'($urandom_range(1, 15)));
        end
      endcase
      allow_idle = (phase != 4);
      for (int n = 0; n < 306; n++) begin
        it = random_item();
        send_item(it, 1'b0, none);
      end
      drain();
    end

    repeat (400) @(posedge clk);
    $display("covered %0d byte items and %0d bit items, %0d results checked",
             bytes_sent, bits_sent, results_seen);
    $display("register settings: defaults plus five written phases");
    if (errors == 0 && pending_probs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/mcpc_pkg.sv
rtl/core/mcpc_ram.sv
rtl/core/mcpc_div.sv
rtl/core/markup_context_probability_calibrator_core.sv
verif/tb.sv
